>>> hdl/swr_pkg.sv
// Package for the sequence window reserver: widths, action and status codes,
// payload structs and the controller-to-datapath command struct.
// No dependencies.
package swr_pkg;

    localparam int ID_W     = 64;
    localparam int SLOTS    = 64;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int STEP     = 256;
    localparam int STEP_LG2 = $clog2(STEP);
    localparam int Q_W      = ID_W - STEP_LG2;
    localparam int SPAN_W   = SLOT_W + 1 + STEP_LG2;

    localparam logic [ID_W-1:0] START_ID_RST = '0;

    localparam logic [1:0] ACT_RESERVE  = 2'd0;
    localparam logic [1:0] ACT_RELEASE  = 2'd1;
    localparam logic [1:0] ACT_COMMIT   = 2'd2;
    localparam logic [1:0] ACT_ROLLBACK = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LOW  = 2'd1;
    localparam logic [1:0] ST_HIGH = 2'd2;
    localparam logic [1:0] ST_USED = 2'd3;

    typedef struct packed {
        logic [1:0]      action;
        logic [ID_W-1:0] seq_num;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  tentative_id;
        logic [SLOTS-1:0] window_bits;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic locate;
        logic span;
        logic finish;
    } t_cmd;

endpackage

>>> hdl/swr_ctrl.sv
// Controller for the sequence window reserver: sequences one item through
// capture, locate, span and finish, and owns the output valid flag. Uses swr_pkg.
module swr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output swr_pkg::t_cmd o_cmd
);
    import swr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOCATE,
        S_SPAN,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOCATE;
                end
            end
            S_LOCATE: begin
                o_cmd.locate = 1'b1;
                n_state      = S_SPAN;
            end
            S_SPAN: begin
                o_cmd.span = 1'b1;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.finish || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/swr_dp.sv
// Datapath for the sequence window reserver: committed id, bitmap, slot
// lookup, highest-slot encoder, commit adder and output register. Uses swr_pkg.
module swr_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  swr_pkg::t_cmd           i_cmd,
    input  swr_pkg::t_in_item       i_in_data,
    input  logic                    i_cfg_we,
    input  logic [swr_pkg::ID_W-1:0] i_cfg_data,
    output swr_pkg::t_out_item      o_out_data
);
    import swr_pkg::*;

    logic [1:0]        r_action;
    logic [ID_W-1:0]   r_seq;
    logic [ID_W-1:0]   r_committed;
    logic [SLOTS-1:0]  r_window;
    logic [1:0]        r_status;
    logic [SPAN_W-1:0] r_span;
    t_out_item         r_out;

    logic [ID_W-1:0]   diff;
    logic [Q_W-1:0]    quot;
    logic              too_low;
    logic              too_high;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        n_status;
    logic [SLOT_W-1:0] top;
    logic              nonzero;
    logic [SPAN_W-1:0] n_span;
    logic [ID_W-1:0]   sum;

    // Slot lookup: a shift stands in for the divide since the step is a power of two.
    always_comb begin
        diff     = r_seq - r_committed;
        quot     = diff[ID_W-1:STEP_LG2];
        too_low  = (r_seq <= r_committed);
        too_high = (quot == '0) || (quot > Q_W'(SLOTS));
        slot     = quot[SLOT_W-1:0] - SLOT_W'(1);
    end

    // Status of the item in the lookup cycle.
    always_comb begin
        n_status = ST_OK;
        if ((r_action == ACT_RESERVE) || (r_action == ACT_RELEASE)) begin
            if (too_low)       n_status = ST_LOW;
            else if (too_high) n_status = ST_HIGH;
            else if ((r_action == ACT_RESERVE) && r_window[slot]) n_status = ST_USED;
        end
    end

    // Highest set slot of the bitmap.
    always_comb begin
        top     = '0;
        nonzero = |r_window;
        for (int i = 0; i < SLOTS; i++) begin
            if (r_window[i]) top = SLOT_W'(i);
        end
        n_span = nonzero ? (SPAN_W'({1'b0, top}) + SPAN_W'(1)) << STEP_LG2 : '0;
    end

    assign sum = r_committed + {{(ID_W-SPAN_W){1'b0}}, r_span};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_in_data.action;
            r_seq    <= i_in_data.seq_num;
        end
        if (i_cmd.span) r_span <= n_span;
        if (i_cmd.locate) r_status <= n_status;
        if (i_cmd.finish) begin
            r_out.status       <= r_status;
            r_out.tentative_id <= sum;
            r_out.window_bits  <= (r_action == ACT_COMMIT) ? '0 : r_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_committed <= START_ID_RST;
            r_window    <= '0;
        end else begin
            if (i_cfg_we) r_committed <= i_cfg_data;
            if (i_cmd.locate && !too_low && !too_high) begin
                if (r_action == ACT_RESERVE) r_window[slot] <= 1'b1;
                if (r_action == ACT_RELEASE) r_window[slot] <= 1'b0;
            end
            if (i_cmd.locate && (r_action == ACT_ROLLBACK)) r_window <= '0;
            if (i_cmd.finish && (r_action == ACT_COMMIT)) begin
                r_committed <= sum;
                r_window    <= '0;
            end
        end
    end

    assign o_out_data = r_out;

endmodule

>>> hdl/sequence_window_reserver.sv
// Top level of the sequence window reserver: joins the controller and the
// datapath. Depends on swr_pkg, swr_ctrl and swr_dp.
//
//   Channel  Handshake                  Payload
//   -------  -------------------------  -------------------------------------
//   in       i_in_valid / o_in_ready    i_in_data  (action, seq_num)
//   out      o_out_valid / i_out_ready  o_out_data (status, tentative_id,
//                                                  window_bits)
//   config   i_cfg_we                   i_cfg_data (start_id)
//
// Each item goes through capture of the transfer, then the slot lookup and
// bitmap update, then the highest-slot encoder, and last the commit adder that
// loads the output register. The output register frees the input side: the next
// item is taken while a result still waits, and only its finish step holds
// until the output register is empty or being drained.
// Reset is synchronous and active low; it loads the committed id with zero and
// clears the bitmap. A config write loads the committed id and keeps the bitmap.
module sequence_window_reserver (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  swr_pkg::t_in_item        i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output swr_pkg::t_out_item       o_out_data,
    input  logic                     i_cfg_we,
    input  logic [swr_pkg::ID_W-1:0] i_cfg_data
);
    import swr_pkg::*;

    // Commands from the controller to the datapath.
    t_cmd cmd;

    swr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cmd      (cmd)
    );

    swr_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_in_data (i_in_data),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .o_out_data(o_out_data)
    );

    // Ready must be low right after an input transfer.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after an input transfer");

    // A slot reported in use must show up in the bitmap.
    a_used_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_USED)) |-> (o_out_data.window_bits != '0))
        else $error("in-use status with an empty bitmap");

    // A new result appears only after an item has been taken in.
    a_result_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result raised without an item in flight");

endmodule
